>>> rtl/core/stroke_font_text_renderer_top_assert.svh
// Assertion macros for the stroke font text renderer.
`ifndef STROKE_FONT_TEXT_RENDERER_TOP_ASSERT_SVH
`define STROKE_FONT_TEXT_RENDERER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SFT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SFT_ASSERT_IMP(label, clk, rst_n, a, c)
`define SFT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/sftr_pkg.sv
// Package: types, constants and stroke ROM of the stroke font text renderer.
package sftr_pkg;
    localparam int GLYPH_WIDTH = 12;
    localparam int GLYPH_COUNT = 31;
    localparam int ROM_GLYPHS  = 31;
    localparam int ROM_SLOTS   = 14;
    localparam int QDEPTH      = 2;

    localparam logic [1:0] K_HLINE = 2'd0;
    localparam logic [1:0] K_VLINE = 2'd1;
    localparam logic [1:0] K_PIXEL = 2'd2;
    localparam logic [1:0] K_NONE  = 2'd3;

    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_AA = 8'h80;
    localparam logic [7:0] C_II = 8'h81;
    localparam logic [7:0] C_U  = 8'h82;
    localparam logic [7:0] C_E  = 8'h83;
    localparam logic [7:0] C_AI = 8'h84;
    localparam logic [7:0] C_O  = 8'h85;
    localparam logic [7:0] C_AN = 8'h86;
    localparam logic [7:0] C_CH = 8'h87;

    // Operation classes handed from the front to the back
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_GLYPH = 2'd1,
        OP_MARK  = 2'd2
    } t_op;

    // One queued job: everything the back needs to emit its commands
    typedef struct packed {
        t_op         op;
        logic [4:0]  glyph;
        logic [7:0]  code;
        logic [15:0] cx;
        logic [15:0] y;
        logic [15:0] mid;
        logic [15:0] width;
    } t_job;

    // Stroke word: kind[13:12] x[11:8] y[7:4] len[3:0]
    function automatic logic [13:0] hs(input int x, input int y, input int l);
        return {2'd0, 4'(x), 4'(y), 4'(l)};
    endfunction
    function automatic logic [13:0] vs(input int x, input int y, input int l);
        return {2'd1, 4'(x), 4'(y), 4'(l)};
    endfunction
    function automatic logic [13:0] px(input int x, input int y);
        return {2'd2, 4'(x), 4'(y), 4'd0};
    endfunction

    function automatic logic [3:0] rom_count(input logic [4:0] g);
        case (g)
            5'd0: return 4'd8;   5'd1: return 4'd10;  5'd2: return 4'd8;
            5'd3: return 4'd5;   5'd4: return 4'd8;   5'd5: return 4'd14;
            5'd6: return 4'd8;   5'd7: return 4'd6;   5'd8: return 4'd8;
            5'd9: return 4'd11;  5'd10: return 4'd12; 5'd11: return 4'd7;
            5'd12: return 4'd6;  5'd13: return 4'd7;  5'd14: return 4'd5;
            5'd15: return 4'd7;  5'd16: return 4'd8;  5'd17: return 4'd8;
            5'd18: return 4'd3;  5'd19: return 4'd6;  5'd20: return 4'd6;
            5'd21: return 4'd5;  5'd22: return 4'd9;  5'd23: return 4'd8;
            5'd24: return 4'd10; 5'd25: return 4'd9;  5'd26: return 4'd9;
            5'd27: return 4'd5;  5'd28: return 4'd6;  5'd29: return 4'd8;
            5'd30: return 4'd12;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [13:0] rom_stroke(input logic [4:0] g, input logic [3:0] k);
        logic [13:0] s [ROM_SLOTS];
        for (int i = 0; i < ROM_SLOTS; i++) s[i] = 14'd0;
        case (g)
            5'd0: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=vs(5,3,8); s[3]=hs(6,3,4);
                s[4]=vs(9,3,3); s[5]=hs(6,6,3); s[6]=vs(9,7,3); s[7]=hs(6,9,4); end
            5'd1: begin s[0]=hs(0,2,8); s[1]=vs(0,2,2); s[2]=vs(6,3,2); s[3]=px(7,5);
                s[4]=px(8,6); s[5]=px(9,7); s[6]=px(8,8); s[7]=px(7,9); s[8]=px(6,10);
                s[9]=px(5,11); end
            5'd2: begin s[0]=hs(0,2,8); s[1]=vs(0,2,2); s[2]=vs(5,3,2); s[3]=hs(4,5,4);
                s[4]=vs(4,5,4); s[5]=vs(7,5,4); s[6]=hs(4,8,4); s[7]=vs(5,9,2); end
            5'd3: begin s[0]=hs(0,2,12); s[1]=vs(10,3,3); s[2]=px(9,6); s[3]=vs(10,7,3);
                s[4]=hs(0,10,11); end
            5'd4: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=hs(5,3,5); s[3]=vs(9,3,3);
                s[4]=px(10,4); s[5]=hs(5,5,4); s[6]=px(8,5); s[7]=vs(5,6,6); end
            5'd5: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=px(5,3); s[3]=px(9,3);
                s[4]=px(6,4); s[5]=px(8,4); s[6]=px(7,5); s[7]=px(6,6); s[8]=px(8,6);
                s[9]=px(5,7); s[10]=px(9,7); s[11]=px(4,8); s[12]=px(10,8);
                s[13]=vs(5,9,3); end
            5'd6: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=px(10,3); s[3]=px(9,4);
                s[4]=px(8,5); s[5]=px(7,6); s[6]=px(6,7); s[7]=vs(5,8,4); end
            5'd7, 5'd12: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=hs(5,3,6);
                s[3]=hs(5,8,6); s[4]=vs(5,3,6); s[5]=vs(10,3,6); end
            5'd8: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=hs(5,3,6); s[3]=px(10,4);
                s[4]=px(9,5); s[5]=px(8,6); s[6]=hs(5,6,3); s[7]=vs(5,7,5); end
            5'd9, 5'd10: begin s[0]=px(5,0); s[1]=px(5,1); s[2]=hs(0,2,12); s[3]=px(10,3);
                s[4]=px(9,4); s[5]=px(8,5); s[6]=px(7,6); s[7]=px(6,7); s[8]=px(5,8);
                s[9]=px(4,9); s[10]=vs(3,10,2); s[11]=px(4,11); end
            5'd11: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=vs(5,3,2); s[3]=px(4,4);
                s[4]=hs(5,5,6); s[5]=vs(10,5,4); s[6]=hs(5,8,6); end
            5'd13: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=hs(5,3,5); s[3]=hs(5,8,5);
                s[4]=vs(5,3,6); s[5]=vs(9,3,6); s[6]=vs(11,2,10); end
            5'd14: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=vs(5,3,5); s[3]=vs(9,3,5);
                s[4]=hs(5,8,5); end
            5'd15: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=hs(5,3,5); s[3]=hs(5,7,5);
                s[4]=vs(5,3,5); s[5]=vs(9,3,5); s[6]=vs(7,8,3); end
            5'd16: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=hs(5,3,2); s[3]=hs(8,3,2);
                s[4]=vs(5,3,5); s[5]=vs(9,3,5); s[6]=hs(5,7,5); s[7]=vs(7,8,3); end
            5'd17: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=vs(5,3,5); s[3]=vs(9,3,5);
                s[4]=hs(5,8,5); s[5]=px(9,9); s[6]=px(10,10); s[7]=px(11,11); end
            5'd18: begin s[0]=hs(0,2,7); s[1]=vs(0,2,2); s[2]=vs(5,3,9); end
            5'd19: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=vs(5,3,6); s[3]=px(6,9);
                s[4]=px(7,10); s[5]=px(8,11); end
            5'd20: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=hs(5,3,5); s[3]=hs(5,7,5);
                s[4]=vs(5,3,5); s[5]=vs(9,3,5); end
            5'd21: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=vs(5,3,6); s[3]=vs(9,3,6);
                s[4]=hs(5,6,5); end
            5'd22: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=hs(5,3,6); s[3]=vs(5,3,3);
                s[4]=vs(10,6,3); s[5]=hs(5,6,6); s[6]=vs(5,6,3); s[7]=vs(10,3,3);
                s[8]=hs(5,9,6); end
            5'd23: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=vs(5,3,3); s[3]=hs(5,6,5);
                s[4]=vs(9,6,3); s[5]=hs(5,9,4); s[6]=px(6,8); s[7]=vs(5,10,2); end
            5'd24: begin s[0]=hs(0,2,12); s[1]=px(1,3); s[2]=px(2,4); s[3]=px(1,5);
                s[4]=vs(4,3,3); s[5]=hs(4,6,5); s[6]=vs(8,6,3); s[7]=hs(4,9,4);
                s[8]=px(5,8); s[9]=vs(4,10,2); end
            5'd25: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=hs(5,3,5); s[3]=hs(5,7,5);
                s[4]=vs(5,3,5); s[5]=vs(9,3,5); s[6]=px(9,8); s[7]=px(10,9);
                s[8]=px(11,10); end
            5'd26: begin s[0]=hs(0,2,8); s[1]=vs(0,2,2); s[2]=vs(5,3,2); s[3]=hs(4,5,4);
                s[4]=vs(4,5,4); s[5]=vs(7,5,4); s[6]=hs(4,8,4); s[7]=vs(5,9,3);
                s[8]=px(6,12); end
            5'd27: begin s[0]=hs(0,2,12); s[1]=vs(0,2,11); s[2]=hs(5,3,6); s[3]=vs(5,3,8);
                s[4]=vs(10,3,6); end
            5'd28: begin s[0]=hs(0,2,12); s[1]=vs(1,3,5); s[2]=vs(5,3,5); s[3]=vs(9,3,5);
                s[4]=hs(1,8,9); s[5]=vs(9,8,3); end
            5'd29: begin s[0]=hs(0,2,12); s[1]=px(1,3); s[2]=px(2,4); s[3]=px(1,5);
                s[4]=hs(4,3,5); s[5]=hs(4,7,5); s[6]=vs(4,3,5); s[7]=vs(8,3,5); end
            5'd30: begin s[0]=px(5,0); s[1]=px(5,1); s[2]=hs(0,2,12); s[3]=hs(7,3,3);
                s[4]=vs(9,3,3); s[5]=hs(7,5,3); s[6]=px(8,6); s[7]=px(7,7); s[8]=px(6,8);
                s[9]=px(5,9); s[10]=px(4,10); s[11]=vs(3,11,2); end
            default: ;
        endcase
        return (k < 4'(ROM_SLOTS)) ? s[k] : 14'd0;
    endfunction

    // Mark count for a vowel sign
    function automatic logic [3:0] mark_count(input logic [7:0] c);
        case (c)
            C_AA: return 4'd1;
            C_II, C_U, C_E, C_AN, C_CH: return 4'd3;
            C_O: return 4'd4;
            C_AI: return 4'd5;
            default: return 4'd0;
        endcase
    endfunction
endpackage

>>> rtl/core/stroke_font_text_renderer_top.sv
// Top level of the stroke font text renderer.
// Usage:
//  s_axis carries one text code per transaction; tdata = {origin_y, origin_x,
//  code} from the top bit down, tuser = start_req (latch origin, reset cursor).
//  m_axis carries one draw command per transaction; tlast marks the last
//  command of a code. Every code yields at least one command (kind 3 if none).
//  i_cfg_* writes the text color; write only while idle. Reset color 0xFFFF.
//  Throughput: one command per cycle from the back stepper while the receiver
//  does not stall; a code yields max(1, command count) commands, up to 14 for the largest glyph.
//  The front writes the job into the queue at the accepting edge; the back
//  then loads its commands one by one into the output register on m_axis.
//  A two-entry job queue lets the front keep taking codes while the back
//  emits; on a receiver stall the output register holds and the queue fills,
//  then s_axis_tready falls. Reset clears cursor, origin, queue and output valid.
module stroke_font_text_renderer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // code[7:0], origin_x[23:8], origin_y[39:24]
    input  logic        s_axis_tuser,  // start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kind[1:0], pos_x[17:2], pos_y[33:18], length[37:34], color[53:38],
    // text_width[69:54], zero fill [71:70]
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import sftr_pkg::*;

    logic [15:0] r_color;
    t_job        f_job, q_job;
    logic        f_valid, f_ready, q_valid, q_ready;
    logic [1:0]  kind;
    logic [15:0] x, y, col, wid;
    logic [3:0]  len;

    assign o_cfg_ready = 1'b1;

    // Hold the color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_color <= 16'hFFFF;
        else if (i_cfg_valid) r_color <= i_cfg_data;
    end

    sftr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_code(s_axis_tdata[7:0]), .i_start(s_axis_tuser), .i_ox(s_axis_tdata[23:8]),
        .i_oy(s_axis_tdata[39:24]), .o_job_valid(f_valid), .i_job_ready(f_ready),
        .o_job(f_job)
    );

    sftr_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .o_ready(f_ready),
        .i_job(f_job), .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    sftr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_job(q_job), .i_color(r_color), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_kind(kind), .o_x(x), .o_y(y), .o_len(len), .o_color(col),
        .o_last(m_axis_tlast), .o_width(wid)
    );

    assign m_axis_tdata = {2'b00, wid, col, len, y, x, kind};
endmodule

>>> rtl/core/sftr_front.sv
// Front: accepts text codes, tracks the cursor and classifies each code into a job.
module sftr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_code,
    input  logic           i_start,
    input  logic [15:0]    i_ox,
    input  logic [15:0]    i_oy,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output sftr_pkg::t_job o_job
);
    import sftr_pkg::*;

    logic [15:0] r_base_x, r_base_y, r_cursor_x, r_prev_x;
    logic [4:0]  r_prev_w;
    logic [15:0] bx, by, cx, px_, mid, n_cursor;
    logic [4:0]  pw, n_prev_w;
    logic [15:0] n_prev_x;
    t_job        job;
    logic        acc;

    assign o_ready     = i_job_ready;
    assign o_job_valid = i_valid;
    assign acc         = i_valid && i_job_ready;

    // Classify the code and work out the next cursor
    always_comb begin
        bx  = i_start ? i_ox : r_base_x;
        by  = i_start ? i_oy : r_base_y;
        cx  = i_start ? i_ox : r_cursor_x;
        px_ = i_start ? i_ox : r_prev_x;
        pw  = i_start ? 5'd0 : r_prev_w;
        mid = px_ + 16'(pw >> 1);
        n_cursor = cx;
        n_prev_x = px_;
        n_prev_w = pw;
        job.op = OP_NONE;
        job.glyph = i_code[4:0];
        job.code = i_code;
        job.cx = cx;
        job.y = by;
        job.mid = mid;
        if (i_code == C_SPACE) begin
            n_cursor = cx + 16'd5;
            n_prev_w = 5'd0;
        end else if (i_code != 8'd0 && !i_code[7]) begin
            n_prev_x = cx;
            n_prev_w = 5'(GLYPH_WIDTH);
            n_cursor = cx + 16'(GLYPH_WIDTH);
            if (i_code < 8'(GLYPH_COUNT) && i_code < 8'(ROM_GLYPHS) &&
                rom_count(i_code[4:0]) != 4'd0) begin
                job.op = OP_GLYPH;
            end
        end else if (i_code[7:3] == 5'b10000) begin
            job.op = OP_MARK;
            if (i_code == C_AA || i_code == C_II || i_code == C_O) begin
                n_cursor = cx + 16'd3;
            end
        end
        job.width = n_cursor - bx;
    end

    assign o_job = job;

    // Hold the string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= '0; r_base_y <= '0; r_cursor_x <= '0;
            r_prev_x <= '0; r_prev_w <= '0;
        end else if (acc) begin
            r_base_x <= bx; r_base_y <= by; r_cursor_x <= n_cursor;
            r_prev_x <= n_prev_x; r_prev_w <= n_prev_w;
        end
    end
endmodule

>>> rtl/core/sftr_queue.sv
// Short job queue between front and back.
module sftr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sftr_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output sftr_pkg::t_job o_job
);
    import sftr_pkg::*;
    `include "stroke_font_text_renderer_top_assert.svh"

    t_job        r_mem [QDEPTH];
    logic [0:0]  r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, pop;

    assign o_ready = (r_cnt != 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    `SFT_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= 2'(QDEPTH))
    `SFT_ASSERT_NXT(a_full_hold, i_clk, i_rst_n, r_cnt == 2'(QDEPTH) && !pop,
        r_cnt == 2'(QDEPTH))
    `SFT_ASSERT_NXT(a_empty_fill, i_clk, i_rst_n, r_cnt == 2'd0 && push, r_cnt == 2'd1)
endmodule

>>> rtl/core/sftr_back.sv
// Back: steps through a job and emits one draw command per cycle while the receiver does not stall.
module sftr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sftr_pkg::t_job i_job,
    input  logic [15:0]    i_color,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_kind,
    output logic [15:0]    o_x,
    output logic [15:0]    o_y,
    output logic [3:0]     o_len,
    output logic [15:0]    o_color,
    output logic           o_last,
    output logic [15:0]    o_width
);
    import sftr_pkg::*;
    `include "stroke_font_text_renderer_top_assert.svh"

    logic [3:0]  r_k;
    logic [3:0]  cnt;
    logic [13:0] s;
    logic [1:0]  kind;
    logic [15:0] x, y;
    logic [3:0]  len;
    logic        last, slot_free, take;

    // Select the current command
    always_comb begin
        s = rom_stroke(i_job.glyph, r_k);
        kind = K_NONE; x = '0; y = '0; len = '0;
        cnt = 4'd1;
        case (i_job.op)
            OP_GLYPH: begin
                cnt  = rom_count(i_job.glyph);
                kind = s[13:12];
                x    = i_job.cx + 16'(s[11:8]);
                y    = i_job.y + 16'(s[7:4]);
                len  = s[3:0];
            end
            OP_MARK: begin
                cnt = mark_count(i_job.code);
                kind = K_PIXEL;
                case (i_job.code)
                    C_AA: begin kind = K_VLINE; x = i_job.cx; y = i_job.y + 16'd2;
                        len = 4'd10; end
                    C_II: case (r_k)
                        4'd0: begin kind = K_VLINE; x = i_job.cx; y = i_job.y + 16'd2;
                            len = 4'd9; end
                        4'd1: begin x = i_job.cx - 16'd1; y = i_job.y + 16'd10; end
                        default: begin x = i_job.cx - 16'd2; y = i_job.y + 16'd11; end
                    endcase
                    C_U: case (r_k)
                        4'd0: begin x = i_job.mid - 16'd1; y = i_job.y + 16'd13; end
                        4'd1: begin x = i_job.mid; y = i_job.y + 16'd14; end
                        default: begin x = i_job.mid + 16'd1; y = i_job.y + 16'd13; end
                    endcase
                    C_E, C_O: case (r_k)
                        4'd0: begin x = i_job.mid + 16'd1; y = i_job.y + 16'd1; end
                        4'd1: begin x = i_job.mid; y = i_job.y; end
                        4'd2: begin x = i_job.mid + 16'd2; y = i_job.y; end
                        default: begin kind = K_VLINE; x = i_job.cx;
                            y = i_job.y + 16'd2; len = 4'd10; end
                    endcase
                    C_AI: case (r_k)
                        4'd0: begin x = i_job.mid - 16'd1; y = i_job.y + 16'd1; end
                        4'd1: begin x = i_job.mid - 16'd2; y = i_job.y; end
                        4'd2: begin x = i_job.mid + 16'd1; y = i_job.y + 16'd1; end
                        4'd3: begin x = i_job.mid; y = i_job.y; end
                        default: begin x = i_job.mid + 16'd2; y = i_job.y; end
                    endcase
                    C_AN: case (r_k)
                        4'd0: begin x = i_job.mid; y = i_job.y; end
                        4'd1: begin x = i_job.mid + 16'd1; y = i_job.y; end
                        default: begin x = i_job.mid; y = i_job.y + 16'd1; end
                    endcase
                    default: case (r_k)
                        4'd0: begin x = i_job.mid - 16'd1; y = i_job.y; end
                        4'd1: begin x = i_job.mid; y = i_job.y - 16'd1; end
                        default: begin x = i_job.mid + 16'd1; y = i_job.y; end
                    endcase
                endcase
            end
            default: ;
        endcase
        last = (r_k + 4'd1 >= cnt);
    end

    assign slot_free = !o_valid || i_ready;
    assign take      = i_valid && slot_free;
    assign o_ready   = take && last;

    // Advance the step counter and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            o_valid <= 1'b0;
        end else begin
            if (slot_free) o_valid <= i_valid;
            if (take) r_k <= last ? 4'd0 : r_k + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_kind <= kind; o_x <= x; o_y <= y; o_len <= len;
            o_color <= i_color; o_last <= last; o_width <= i_job.width;
        end
    end

    `SFT_ASSERT_IMP(a_k_range, i_clk, i_rst_n, 1'b1, r_k < 4'(ROM_SLOTS))
    `SFT_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_x) && $stable(o_last))
    `SFT_ASSERT_NXT(a_step_clear, i_clk, i_rst_n, take && last, r_k == 4'd0)
endmodule

>>> bench/tb_stroke_font_text_renderer_top.sv
// Testbench for the stroke font text renderer: random and directed text codes, scoreboard check.
`timescale 1ns / 100ps

module tb_stroke_font_text_renderer_top;
    import sftr_pkg::*;

    // One expected draw command
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [3:0]  length;
        logic [15:0] color;
        logic        run_last;
        logic [15:0] text_width;
    } t_cmd;

    // Predicts draw commands from accepted codes and checks the output stream
    class render_scoreboard;
        logic [15:0] color_reg;
        logic [15:0] org_x, org_y, cur_x, glyph_x;
        logic [4:0]  glyph_w;
        t_cmd        pending[$];
        t_cmd        run[$];
        int          errors;
        int          checked;

        function void init();
            color_reg = 16'hFFFF;
            org_x = 0; org_y = 0; cur_x = 0; glyph_x = 0; glyph_w = 0;
            pending.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void add(logic [1:0] k, logic [15:0] x, logic [15:0] y, logic [3:0] l);
            t_cmd c;
            c = '{kind: k, pos_x: x, pos_y: y, length: l, color: color_reg,
                  run_last: 1'b0, text_width: 16'd0};
            if (run.size() < 14) run.push_back(c);
        endfunction

        // Work out the commands for one accepted code
        function void note_code(logic [7:0] code, logic start, logic [15:0] ox,
                                logic [15:0] oy);
            logic [15:0] cx, y, m, w;
            logic [13:0] s;
            int cnt;
            run.delete();
            if (start) begin
                org_x = ox; org_y = oy; cur_x = ox; glyph_x = ox; glyph_w = 0;
            end
            cx = cur_x;
            y = org_y;
            m = glyph_x + 16'(glyph_w >> 1);
            if (code == C_SPACE) begin
                cur_x = cx + 16'd5;
                glyph_w = 0;
            end else if (code >= 8'd1 && code < 8'h80) begin
                glyph_x = cx;
                glyph_w = 5'(GLYPH_WIDTH);
                if (code < GLYPH_COUNT && code < ROM_GLYPHS) begin
                    cnt = rom_count(code[4:0]);
                    for (int k = 0; k < cnt; k++) begin
                        s = rom_stroke(code[4:0], 4'(k));
                        add(s[13:12], cx + 16'(s[11:8]), y + 16'(s[7:4]), s[3:0]);
                    end
                end
                cur_x = cx + 16'(GLYPH_WIDTH);
            end else begin
                case (code)
                    C_AA: begin
                        add(K_VLINE, cx, y + 16'd2, 4'd10);
                        cur_x = cx + 16'd3;
                    end
                    C_II: begin
                        add(K_VLINE, cx, y + 16'd2, 4'd9);
                        add(K_PIXEL, cx - 16'd1, y + 16'd10, 4'd0);
                        add(K_PIXEL, cx - 16'd2, y + 16'd11, 4'd0);
                        cur_x = cx + 16'd3;
                    end
                    C_U: begin
                        add(K_PIXEL, m - 16'd1, y + 16'd13, 4'd0);
                        add(K_PIXEL, m, y + 16'd14, 4'd0);
                        add(K_PIXEL, m + 16'd1, y + 16'd13, 4'd0);
                    end
                    C_E, C_O: begin
                        add(K_PIXEL, m + 16'd1, y + 16'd1, 4'd0);
                        add(K_PIXEL, m, y, 4'd0);
                        add(K_PIXEL, m + 16'd2, y, 4'd0);
                        if (code == C_O) begin
                            add(K_VLINE, cx, y + 16'd2, 4'd10);
                            cur_x = cx + 16'd3;
                        end
                    end
                    C_AI: begin
                        add(K_PIXEL, m - 16'd1, y + 16'd1, 4'd0);
                        add(K_PIXEL, m - 16'd2, y, 4'd0);
                        add(K_PIXEL, m + 16'd1, y + 16'd1, 4'd0);
                        add(K_PIXEL, m, y, 4'd0);
                        add(K_PIXEL, m + 16'd2, y, 4'd0);
                    end
                    C_AN: begin
                        add(K_PIXEL, m, y, 4'd0);
                        add(K_PIXEL, m + 16'd1, y, 4'd0);
                        add(K_PIXEL, m, y + 16'd1, 4'd0);
                    end
                    C_CH: begin
                        add(K_PIXEL, m - 16'd1, y, 4'd0);
                        add(K_PIXEL, m, y - 16'd1, 4'd0);
                        add(K_PIXEL, m + 16'd1, y, 4'd0);
                    end
                    default: ;
                endcase
            end
            if (run.size() == 0) add(K_NONE, 16'd0, 16'd0, 4'd0);
            w = cur_x - org_x;
            foreach (run[i]) begin
                run[i].text_width = w;
                run[i].run_last = (i == run.size() - 1);
                pending.push_back(run[i]);
            end
        endfunction

        // Compare one output transaction with the oldest expectation
        task check_cmd(t_cmd got);
            t_cmd e;
            checked++;
            if (pending.size() == 0) begin
                report("unexpected command", got, got);
                return;
            end
            e = pending.pop_front();
            if (got.kind != e.kind) report("kind", got, e);
            if (got.pos_x != e.pos_x) report("pos_x", got, e);
            if (got.pos_y != e.pos_y) report("pos_y", got, e);
            if (got.length != e.length) report("length", got, e);
            if (got.color != e.color) report("color", got, e);
            if (got.run_last != e.run_last) report("tlast", got, e);
            if (got.text_width != e.text_width) report("text_width", got, e);
        endtask

        task report(string what, t_cmd got, t_cmd want);
            errors++;
            $display("mismatch %s: got %h want %h", what, got, want);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    render_scoreboard sb;
    int send_idle_pct, recv_idle_pct;
    int quiet_cycles;
    int n_codes;

    stroke_font_text_renderer_top u_dut (.*);

    always #6 i_clk = ~i_clk;

    // Sample output transactions and count idle cycles
    always @(posedge i_clk) begin
        t_cmd got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tdata[1:0];
            got.pos_x = m_axis_tdata[17:2];
            got.pos_y = m_axis_tdata[33:18];
            got.length = m_axis_tdata[37:34];
            got.color = m_axis_tdata[53:38];
            got.text_width = m_axis_tdata[69:54];
            got.run_last = m_axis_tlast;
            sb.check_cmd(got);
        end
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (quiet_cycles > 5000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stalls at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one code; tvalid stays up until the next call or a drain drops it
    task automatic send_code(logic [7:0] code, logic start, logic [15:0] ox,
                             logic [15:0] oy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {oy, ox, code};
        s_axis_tuser <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_code(code, start, ox, oy);
        n_codes++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_color(logic [15:0] c);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.color_reg = c;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random code, mostly well-formed text
    task automatic random_code();
        int r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 50) c = 8'($urandom_range(1, 30));
        else if (r < 62) c = C_SPACE;
        else if (r < 84) c = 8'h80 + 8'($urandom_range(7));
        else if (r < 92) c = 8'($urandom_range(31, 127));
        else c = 8'($urandom_range(0, 255));
        send_code(c, $urandom_range(9) == 0, 16'($urandom), 16'($urandom));
    endtask

    initial begin
        sb = new();
        sb.init();
        quiet_cycles = 0;
        n_codes = 0;
        send_idle_pct = 31;
        recv_idle_pct = 64;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset state marks, every glyph, vowel signs, edges of the fields
        send_code(C_U, 1'b0, 16'd0, 16'd0);
        send_code(8'd5, 1'b1, 16'hFFFA, 16'hFFFC);
        send_code(C_U, 1'b0, 16'hFFFF, 16'hFFFF);
        send_code(C_CH, 1'b0, 16'h0, 16'h0);
        send_code(C_SPACE, 1'b0, 16'h0, 16'h0);
        send_code(C_AI, 1'b0, 16'h0, 16'h0);
        send_code(8'd0, 1'b1, 16'h8000, 16'h7FFF);
        send_code(C_II, 1'b0, 16'h0, 16'h0);
        send_code(8'd127, 1'b0, 16'h0, 16'h0);
        send_code(C_E, 1'b0, 16'h0, 16'h0);
        send_code(C_O, 1'b0, 16'h0, 16'h0);
        send_code(C_AN, 1'b0, 16'h0, 16'h0);
        send_code(C_AA, 1'b0, 16'h0, 16'h0);
        send_code(8'hFF, 1'b1, 16'h7FFF, 16'h8000);
        send_code(8'd31, 1'b0, 16'h5555, 16'hAAAA);
        send_code(8'h88, 1'b0, 16'h0, 16'h0);
        for (int g = 1; g < 31; g += 3) send_code(8'(g), 1'b0, 16'h0, 16'h0);

        // Hold off until everything has come out, then recolor
        write_color(16'h0000);
        for (int g = 2; g < 31; g += 3) send_code(8'(g), 1'b0, 16'h0, 16'h0);
        write_color(16'hA5C3);
        for (int g = 3; g < 31; g += 3) send_code(8'(g), 1'b0, 16'h0, 16'h0);

        for (int i = 0; i < 64; i++) begin
            if (i == 21) begin
                send_idle_pct = 64;
                recv_idle_pct = 31;
                write_color(16'(($urandom)));
            end else if (i == 42) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                write_color(16'hFFFF);
            end
            random_code();
        end

        drain();
        $display("covered %0d codes and %0d draw commands over four colors",
                 n_codes, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
